// File: rtl/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg
// Shared types and constants for the free block fifo allocator: word
// layouts of both channels, request modes and result status codes.
// ----------------------------------------------------------------------------
package fba_pkg;

  // fixed field widths of the channel words
  localparam int BLK_W  = 15;
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;
  localparam int FILL_W = 7;

  // parameter defaults
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int BLOCK_BITS_DEF  = 15;

  // first block number that a format enqueues
  localparam logic [BLK_W-1:0] FIRST_FMT_BLOCK = BLK_W'(3);

  // request modes
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FMT   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DUP   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

  // request word
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BLK_W-1:0]  block;
  } fba_in_t;

  // result word
  typedef struct packed {
    logic [BLK_W-1:0]  block_out;
    logic [STAT_W-1:0] status;
    logic [FILL_W-1:0] fill;
  } fba_out_t;

endpackage

// File: rtl/free_block_fifo_allocator.sv
// ----------------------------------------------------------------------------
// free_block_fifo_allocator
// First-in first-out queue of free disc block numbers with duplicate
// rejection on free, pop on allocate and a refill sweep on format.
//
//   channel   ports                          word
//   -------   ----------------------------   ---------
//   request   in_valid / in_ready            fba_in_t
//   result    out_valid / out_ready          fba_out_t
//   config    cfg_wr_en / cfg_wr_data        total_blocks
//
// Free scans the queue and stops early on a hit: the scan reads one
// queued entry a cycle, checks it in one comparator. Allocate pops the
// head (or reports empty), format refills the store (one store write a
// cycle), an unused mode goes straight to the result; each then passes
// the result hand-off. One request is in work at a time; a new one is taken
// while the output register still holds the last result. Reset empties it.
// ----------------------------------------------------------------------------
module free_block_fifo_allocator
  import fba_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int BLOCK_BITS  = BLOCK_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  fba_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output fba_out_t         out_data,
  input  logic             cfg_wr_en,
  input  logic [BLK_W-1:0] cfg_wr_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [BLK_W-1:0]      total_blocks_r;
  logic                  out_valid_r;
  fba_out_t              out_data_r;
  logic                  res_valid;
  logic                  res_ready;
  fba_out_t              res_data;
  logic                  mem_we;
  logic [PW-1:0]         mem_waddr;
  logic [BLOCK_BITS-1:0] mem_wdata;
  logic                  mem_re;
  logic [PW-1:0]         mem_raddr;
  logic [BLOCK_BITS-1:0] mem_rdata;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_blocks_r <= '0;
    end else if (cfg_wr_en) begin
      total_blocks_r <= cfg_wr_data;
    end
  end

  // output register, loads whenever it is empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // sequencer
  fba_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .BLOCK_BITS  (BLOCK_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_total (total_blocks_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // block number store
  fba_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (BLOCK_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

endmodule

// File: rtl/fba_mem.sv
// ----------------------------------------------------------------------------
// fba_mem
// Simple dual port block number store: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module fba_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 15
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered data in the cycle after the address
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/fba_ctrl.sv
// ----------------------------------------------------------------------------
// fba_ctrl
// Request sequencer: holds the queue pointers and count, walks the queued
// entries through one shared comparator for the duplicate check, and
// writes one block per cycle during a format.
// ----------------------------------------------------------------------------
module fba_ctrl
  import fba_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int BLOCK_BITS  = BLOCK_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  fba_in_t                        in_data,
  input  logic [BLK_W-1:0]               cfg_total,
  output logic                           res_valid,
  input  logic                           res_ready,
  output fba_out_t                       res_data,
  output logic                           mem_we,
  output logic [$clog2(QUEUE_DEPTH)-1:0] mem_waddr,
  output logic [BLOCK_BITS-1:0]          mem_wdata,
  output logic                           mem_re,
  output logic [$clog2(QUEUE_DEPTH)-1:0] mem_raddr,
  input  logic [BLOCK_BITS-1:0]          mem_rdata
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_POP  = 5'b00100,
    S_FMT  = 5'b01000,
    S_DONE = 5'b10000
  } fba_state_t;

  fba_state_t state_r, state_nxt;
  logic [PW-1:0]         head_r, head_nxt;
  logic [PW-1:0]         tail_r, tail_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [PW-1:0]         scan_ptr_r, scan_ptr_nxt;
  logic [CW-1:0]         scan_cnt_r, scan_cnt_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic [BLOCK_BITS-1:0] blk_r, blk_nxt;
  logic [BLK_W-1:0]      fmt_blk_r, fmt_blk_nxt;
  logic [BLK_W-1:0]      lim_r, lim_nxt;
  logic [BLK_W-1:0]      got_r, got_nxt;
  logic [STAT_W-1:0]     status_r, status_nxt;

  logic [BLOCK_BITS-1:0] in_blk_bw;
  logic [BLOCK_BITS-1:0] fmt_blk_bw;
  logic [BLK_W-1:0]      rd_blk;
  logic [BLK_W-1:0]      cfg_lim;
  logic [FILL_W-1:0]     fill_w;
  logic                  hit;

  // pointer step with wrap at the queue depth
  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    if (p == PTR_LAST) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // width adaption between word fields and the stored block width
  for (genvar i = 0; i < BLOCK_BITS; i++) begin : g_to_store
    if (i < BLK_W) begin : g_bit
      assign in_blk_bw[i]  = in_data.block[i];
      assign fmt_blk_bw[i] = fmt_blk_r[i];
    end else begin : g_zero
      assign in_blk_bw[i]  = 1'b0;
      assign fmt_blk_bw[i] = 1'b0;
    end
  end

  for (genvar i = 0; i < BLK_W; i++) begin : g_to_word
    if (i < BLOCK_BITS) begin : g_bit
      assign rd_blk[i]  = mem_rdata[i];
      assign cfg_lim[i] = cfg_total[i];
    end else begin : g_zero
      assign rd_blk[i]  = 1'b0;
      assign cfg_lim[i] = 1'b0;
    end
  end

  for (genvar i = 0; i < FILL_W; i++) begin : g_fill
    if (i < CW) begin : g_bit
      assign fill_w[i] = count_r[i];
    end else begin : g_zero
      assign fill_w[i] = 1'b0;
    end
  end

  // shared comparator of the duplicate scan
  assign hit = cmp_vld_r && (mem_rdata == blk_r);

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    scan_ptr_nxt = scan_ptr_r;
    scan_cnt_nxt = scan_cnt_r;
    cmp_vld_nxt  = cmp_vld_r;
    blk_nxt      = blk_r;
    fmt_blk_nxt  = fmt_blk_r;
    lim_nxt      = lim_r;
    got_nxt      = got_r;
    status_nxt   = status_r;
    mem_we       = 1'b0;
    mem_waddr    = tail_r;
    mem_wdata    = blk_r;
    mem_re       = 1'b0;
    mem_raddr    = scan_ptr_r;
    in_ready     = 1'b0;
    res_valid    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          blk_nxt    = in_blk_bw;
          got_nxt    = '0;
          status_nxt = STAT_OK;
          unique case (in_data.mode)
            MODE_FREE: begin
              scan_ptr_nxt = head_r;
              scan_cnt_nxt = '0;
              cmp_vld_nxt  = 1'b0;
              state_nxt    = S_SCAN;
            end
            MODE_ALLOC: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_r;
                state_nxt = S_POP;
              end
            end
            MODE_FMT: begin
              head_nxt    = '0;
              tail_nxt    = '0;
              count_nxt   = '0;
              fmt_blk_nxt = FIRST_FMT_BLOCK;
              lim_nxt     = cfg_lim;
              state_nxt   = S_FMT;
            end
            MODE_NOP: begin
              state_nxt = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          status_nxt = STAT_DUP;
          state_nxt  = S_DONE;
        end else if (scan_cnt_r == count_r) begin
          if (cmp_vld_r) begin
            // last compare came back clean, settle next cycle
            cmp_vld_nxt = 1'b0;
          end else if (count_r == CNT_FULL) begin
            status_nxt = STAT_FULL;
            state_nxt  = S_DONE;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = tail_r;
            mem_wdata = blk_r;
            tail_nxt  = wrap_inc(tail_r);
            count_nxt = count_r + 1'b1;
            state_nxt = S_DONE;
          end
        end else begin
          mem_re       = 1'b1;
          mem_raddr    = scan_ptr_r;
          scan_ptr_nxt = wrap_inc(scan_ptr_r);
          scan_cnt_nxt = scan_cnt_r + 1'b1;
          cmp_vld_nxt  = 1'b1;
        end
      end

      S_POP: begin
        got_nxt   = rd_blk;
        head_nxt  = wrap_inc(head_r);
        count_nxt = count_r - 1'b1;
        state_nxt = S_DONE;
      end

      S_FMT: begin
        if ((fmt_blk_r < lim_r) && (count_r != CNT_FULL)) begin
          mem_we      = 1'b1;
          mem_waddr   = tail_r;
          mem_wdata   = fmt_blk_bw;
          tail_nxt    = wrap_inc(tail_r);
          count_nxt   = count_r + 1'b1;
          fmt_blk_nxt = fmt_blk_r + 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
      scan_ptr_r <= '0;
      scan_cnt_r <= '0;
      cmp_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      count_r    <= count_nxt;
      scan_ptr_r <= scan_ptr_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
    end
  end

  // request payload and result fields
  always_ff @(posedge clk) begin
    blk_r     <= blk_nxt;
    fmt_blk_r <= fmt_blk_nxt;
    lim_r     <= lim_nxt;
    got_r     <= got_nxt;
    status_r  <= status_nxt;
  end

  assign res_data.block_out = got_r;
  assign res_data.status    = status_r;
  assign res_data.fill      = fill_w;

endmodule

// File: rtl/fba_checker.sv
// ----------------------------------------------------------------------------
// fba_checker
// Port level checks for the free block fifo allocator, bound to the top
// level.
// ----------------------------------------------------------------------------
module fba_checker
  import fba_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input fba_out_t out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in work");

  // only a good allocate hands out a block
  a_block_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STAT_OK) |-> out_data.block_out == '0)
    else $error("block given with a failing status");

  // empty report leaves the queue empty
  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STAT_EMPTY) |-> out_data.fill == '0)
    else $error("empty status with queued blocks");

  // a duplicate needs something queued
  a_dup_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STAT_DUP) |-> out_data.fill != '0)
    else $error("duplicate status with an empty queue");

endmodule

bind free_block_fifo_allocator fba_checker u_fba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
